FILE: src/pfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_pkg: shared types and constants of the Phong fragment shader
// Vector types, fixed-point widths, register indexes and stage latencies.
// ----------------------------------------------------------------------------
package pfs_pkg;

	// unit vector components, signed Q2.14
	localparam int U_W = 16;
	typedef logic [2:0][U_W-1:0] uvec_t;

	// clamped cosines and the specular power, Q2.14 with headroom
	localparam int D_W = 16;
	localparam logic [D_W-1:0] ONE_Q14 = D_W'(16384);

	// specular power chain: one stage per possible exponent step
	localparam int SHIN_W = 8;
	localparam int POW_N = (1 << SHIN_W) - 1;

	// lighting back end stages
	localparam int LIGHT_LAT = 3;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AMBIENT   = 3'd0,
		CFG_LIGHT_RGB = 3'd1,
		CFG_LIGHT_DIR = 3'd2,
		CFG_SPEC_GAIN = 3'd3,
		CFG_SHININESS = 3'd4
	} cfg_idx_t;

	// latency of the vector normalizer for a given component width
	function automatic int norm_lat(input int in_w);
		return in_w + 32;
	endfunction

endpackage

FILE: src/pfs_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_delay: enabled shift line
// Carries side data alongside the arithmetic pipeline, DEPTH registers deep.
// ----------------------------------------------------------------------------
module pfs_delay #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);
	logic [W-1:0] tap_q [DEPTH];

	// shift one place per pipeline advance
	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= din;
			for (int k = 1; k < DEPTH; k++) begin
				tap_q[k] <= tap_q[k-1];
			end
		end
	end

	assign dout = tap_q[DEPTH-1];

endmodule

FILE: src/pfs_norm3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_norm3: pipelined 3-vector normalizer
// Sum of squares, bit-per-stage square root, bit-per-stage division of each
// component by the length. A zero vector comes out as zero. Output Q2.14.
// ----------------------------------------------------------------------------
module pfs_norm3 #(
	parameter int IN_W = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [2:0][IN_W-1:0] vin,
	output pfs_pkg::uvec_t       unit
);
	import pfs_pkg::*;

	localparam int SH    = 28;
	localparam int SQ_W  = 2 * IN_W;
	localparam int X_W   = SQ_W + SH;
	localparam int SQ_N  = X_W / 2;
	localparam int LEN_W = SQ_N;
	localparam int DV_W  = IN_W + SH;
	localparam int Q_N   = U_W - 1;
	localparam int LAST  = SQ_N + Q_N + 2;

	logic [2:0]            neg_in;
	logic [2:0][IN_W-1:0]  mag_in;
	logic [SQ_W-1:0]       sq_s0 [3];
	logic [2:0][IN_W-1:0]  mag_s [SQ_N+2];
	logic [2:0]            neg_s [LAST];
	logic                  zero_s [1:LAST-1];
	logic [SQ_W+1:0]       l2;
	logic [X_W-1:0]        rx_s [SQ_N+1];
	logic [X_W-1:0]        rr_s [SQ_N+1];
	logic [2:0][DV_W-1:0]  rem_s [Q_N];
	logic [2:0][Q_N-1:0]   quo_s [Q_N];
	logic [LEN_W-1:0]      len_s [Q_N];
	uvec_t                 unit_q;

	// sign and magnitude split
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg_in[i] = vin[i][IN_W-1];
			mag_in[i] = neg_in[i] ? IN_W'(-vin[i]) : vin[i];
		end
	end

	// stage 0: squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s0[i] <= SQ_W'(mag_in[i]) * SQ_W'(mag_in[i]);
			end
			mag_s[0] <= mag_in;
			neg_s[0] <= neg_in;
		end
	end

	// stage 1: squared length, scaled for a Q.14 root
	assign l2 = (SQ_W+2)'(sq_s0[0]) + (SQ_W+2)'(sq_s0[1]) + (SQ_W+2)'(sq_s0[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s[0]   <= {l2[SQ_W-1:0], {SH{1'b0}}};
			rr_s[0]   <= '0;
			mag_s[1]  <= mag_s[0];
			neg_s[1]  <= neg_s[0];
			zero_s[1] <= (l2 == '0);
		end
	end

	// square root, one result bit per stage
	for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
		localparam logic [X_W-1:0] BIT = X_W'(1) << (2 * (SQ_N - 1 - k));
		logic [X_W:0] trial;
		logic         take;

		assign trial = {1'b0, rr_s[k]} + {1'b0, BIT};
		assign take  = ({1'b0, rx_s[k]} >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rx_s[k+1]   <= take ? rx_s[k] - trial[X_W-1:0] : rx_s[k];
				rr_s[k+1]   <= take ? (rr_s[k] >> 1) + BIT : rr_s[k] >> 1;
				mag_s[k+2]  <= mag_s[k+1];
				neg_s[k+2]  <= neg_s[k+1];
				zero_s[k+2] <= zero_s[k+1];
			end
		end
	end

	// restoring division of each magnitude by the length
	for (genvar k = 0; k < Q_N; k++) begin : g_div
		logic [2:0][DV_W-1:0] rem_in;
		logic [2:0][Q_N-1:0]  quo_in;
		logic [LEN_W-1:0]     len_in;
		logic [DV_W:0]        dvs;
		logic [2:0]           take;

		if (k == 0) begin : g_first
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					rem_in[i] = {mag_s[SQ_N+1][i], {SH{1'b0}}};
				end
				quo_in = '0;
				len_in = rr_s[SQ_N][LEN_W-1:0];
			end
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign quo_in = quo_s[k-1];
			assign len_in = len_s[k-1];
		end

		assign dvs = (DV_W+1)'(len_in) << (Q_N - 1 - k);

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				take[i] = ({1'b0, rem_in[i]} >= dvs);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					rem_s[k][i] <= take[i] ? DV_W'({1'b0, rem_in[i]} - dvs) : rem_in[i];
					quo_s[k][i] <= quo_in[i] | (Q_N'(take[i]) << (Q_N - 1 - k));
				end
				len_s[k]           <= len_in;
				neg_s[SQ_N+2+k]    <= neg_s[SQ_N+1+k];
				zero_s[SQ_N+2+k]   <= zero_s[SQ_N+1+k];
			end
		end
	end

	// sign restore, zero vector forced to zero
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (zero_s[LAST-1]) begin
					unit_q[i] <= '0;
				end else if (neg_s[LAST-1][i]) begin
					unit_q[i] <= -(U_W'(quo_s[Q_N-1][i]));
				end else begin
					unit_q[i] <= U_W'(quo_s[Q_N-1][i]);
				end
			end
		end
	end

	assign unit = unit_q;

endmodule

FILE: src/pfs_power.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_power: specular exponent chain
// One truncating Q2.14 multiply per stage; stage k applies only while k is
// below the shininess exponent.
// ----------------------------------------------------------------------------
module pfs_power (
	input  logic                        clk,
	input  logic                        en,
	input  logic [pfs_pkg::D_W-1:0]     cos_in,
	input  logic [pfs_pkg::SHIN_W-1:0]  shin,
	output logic [pfs_pkg::D_W-1:0]     pow
);
	import pfs_pkg::*;

	logic [D_W-1:0] p_s [POW_N];
	logic [D_W-1:0] c_s [POW_N];

	for (genvar k = 0; k < POW_N; k++) begin : g_stage
		logic [D_W-1:0]   p_in;
		logic [D_W-1:0]   c_in;
		logic [2*D_W-1:0] prod;

		if (k == 0) begin : g_first
			assign p_in = ONE_Q14;
			assign c_in = cos_in;
		end else begin : g_next
			assign p_in = p_s[k-1];
			assign c_in = c_s[k-1];
		end

		assign prod = (2*D_W)'(p_in) * (2*D_W)'(c_in);

		// multiply or pass through
		always_ff @(posedge clk) begin
			if (en) begin
				p_s[k] <= (SHIN_W'(k) < shin) ? prod[D_W+13:14] : p_in;
				c_s[k] <= c_in;
			end
		end
	end

	assign pow = p_s[POW_N-1];

endmodule

FILE: src/pfs_light.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_light: per-channel color sum
// Ambient, diffuse and specular terms in Q.30, rounded half up and clamped.
// The last stage is the output register of the block.
// ----------------------------------------------------------------------------
module pfs_light (
	input  logic                     clk,
	input  logic                     en,
	input  logic [2:0][8:0]          base,
	input  logic [2:0][15:0]         amb,
	input  logic [2:0][15:0]         lrgb,
	input  logic [15:0]              gain,
	input  logic [pfs_pkg::D_W-1:0]  diff,
	input  logic [pfs_pkg::D_W-1:0]  spec,
	output logic [2:0][7:0]          color
);
	import pfs_pkg::*;

	logic [24:0]     ba_s1 [3];
	logic [24:0]     bd_s1 [3];
	logic [31:0]     gp_s1;
	logic [2:0][15:0] lc_s1;
	logic [D_W-1:0]  d_s1;
	logic [38:0]     t1_s2 [3];
	logic [40:0]     t2_s2 [3];
	logic [47:0]     t3_s2 [3];
	logic [2:0][7:0] color_s3;

	// first products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				ba_s1[c] <= 25'(base[c]) * 25'(amb[c]);
				bd_s1[c] <= 25'(base[c]) * 25'(lrgb[c]);
			end
			gp_s1 <= 32'(gain) * 32'(spec);
			lc_s1 <= lrgb;
			d_s1  <= diff;
		end
	end

	// second products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				t1_s2[c] <= {ba_s1[c], 14'd0};
				t2_s2[c] <= 41'(bd_s1[c]) * 41'(d_s1);
				t3_s2[c] <= 48'(gp_s1) * 48'(lc_s1[c]);
			end
		end
	end

	// sum, round, saturate
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				logic [49:0] sum;
				sum = 50'(t1_s2[c]) + 50'(t2_s2[c]) + 50'(t3_s2[c]) + (50'(1) << 29);
				color_s3[c] <= (|sum[49:38]) ? 8'hff : sum[37:30];
			end
		end
	end

	assign color = color_s3;

endmodule

FILE: src/phong_fragment_shader_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phong_fragment_shader_core: fixed-point Phong lighting of one fragment
// Takes one fragment and returns one lit pixel per clock while not stalled.
// ----------------------------------------------------------------------------
// A fragment is taken on every clock at which the input is offered and the
// output side is not held; results leave in input order after passing
// through two 48/49-stage normalizers, the 255-stage specular power chain
// and a handful of multiply stages. The whole pipeline advances
// together: while a finished pixel waits on m_tready, everything holds and
// s_tready is low, otherwise a new fragment enters each cycle. Configuration
// registers are written with cfg_we and are to be changed only when the
// pipeline is empty.
module phong_fragment_shader_core #(
	parameter int IMG_HEIGHT = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [pfs_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [47:0]                     cfg_wdata,
	// fragment in
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, base_red, base_green,
	// base_blue, screen_x, screen_y, zero pad
	input  logic [151:0]                    s_tdata,
	// pixel out
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// pixel_x, pixel_y, out_red, out_green, out_blue, zero pad
	output logic [47:0]                     m_tdata
);
	import pfs_pkg::*;

	localparam int NL16  = norm_lat(16);
	localparam int NL17  = norm_lat(17);
	localparam int D_DLY = NL17 + 2 + POW_N;
	localparam int B_DLY = NL16 + 4 + D_DLY;
	localparam int TOTAL = B_DLY + LIGHT_LAT;
	localparam logic [9:0] ROW_TOP = 10'(IMG_HEIGHT - 1);

	logic             adv;
	logic [TOTAL-1:0] vld_q;

	logic [47:0]       amb_q;
	logic [47:0]       lrgb_q;
	logic [47:0]       ldir_q;
	logic [15:0]       gain_q;
	logic [SHIN_W-1:0] shin_q;

	uvec_t            pos_in, nrm_in, ldir_vec;
	uvec_t            u_l, u_n, u_p, u_r, vdl;
	logic [19:0]      pix_in, pix_dl;
	logic [26:0]      base_in, base_dl;

	logic signed [31:0] nl_s1 [3];
	uvec_t              vneg_s1, l_s1, n_s1, l_s2, n_s2, l_s3;
	logic signed [31:0] dnl_s2;
	logic signed [47:0] m_s3 [3];
	logic [D_W-1:0]     d_s3, d_s4;
	logic [2:0][16:0]   r_s4;
	logic signed [31:0] rv_s5 [3];
	logic signed [31:0] drv;
	logic [D_W-1:0]     s_s6;
	logic [D_W-1:0]     pow, d_dl;
	logic [2:0][7:0]    color;

	// global advance: hold everything while the output is stalled
	assign adv      = !vld_q[TOTAL-1] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[TOTAL-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[TOTAL-2:0], s_tvalid};
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amb_q  <= '0;
			lrgb_q <= '0;
			ldir_q <= '0;
			gain_q <= '0;
			shin_q <= SHIN_W'(1);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_AMBIENT:   amb_q  <= cfg_wdata;
				CFG_LIGHT_RGB: lrgb_q <= cfg_wdata;
				CFG_LIGHT_DIR: ldir_q <= cfg_wdata;
				CFG_SPEC_GAIN: gain_q <= cfg_wdata[15:0];
				CFG_SHININESS: shin_q <= cfg_wdata[SHIN_W-1:0];
				default: ;
			endcase
		end
	end

	// input unpacking
	assign pos_in   = s_tdata[47:0];
	assign nrm_in   = s_tdata[95:48];
	assign base_in  = s_tdata[122:96];
	assign ldir_vec = ldir_q;
	assign pix_in   = {ROW_TOP - s_tdata[150:141], s_tdata[136:127]};

	// normalize light, normal and position
	pfs_norm3 #(.IN_W(16)) u_norm_l (.clk(clk), .en(adv), .vin(ldir_vec), .unit(u_l));
	pfs_norm3 #(.IN_W(16)) u_norm_n (.clk(clk), .en(adv), .vin(nrm_in), .unit(u_n));
	pfs_norm3 #(.IN_W(16)) u_norm_p (.clk(clk), .en(adv), .vin(pos_in), .unit(u_p));

	// n.l products, view vector
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				nl_s1[i]   <= $signed(u_n[i]) * $signed(u_l[i]);
				vneg_s1[i] <= -u_p[i];
			end
			l_s1 <= u_l;
			n_s1 <= u_n;
		end
	end

	// n.l sum
	always_ff @(posedge clk) begin
		if (adv) begin
			dnl_s2 <= nl_s1[0] + nl_s1[1] + nl_s1[2];
			l_s2   <= l_s1;
			n_s2   <= n_s1;
		end
	end

	// 2(n.l)n scaled products, diffuse cosine
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				m_s3[i] <= dnl_s2 * $signed(n_s2[i]);
			end
			d_s3 <= (dnl_s2 > 0) ? dnl_s2[29:14] : '0;
			l_s3 <= l_s2;
		end
	end

	// reflection vector, floor shift then subtract light
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				r_s4[i] <= 17'((m_s3[i] >>> 27) - $signed(l_s3[i]));
			end
			d_s4 <= d_s3;
		end
	end

	pfs_norm3 #(.IN_W(17)) u_norm_r (.clk(clk), .en(adv), .vin(r_s4), .unit(u_r));

	pfs_delay #(.W(48), .DEPTH(NL17 + 3)) u_dly_v (
		.clk(clk), .en(adv), .din(vneg_s1), .dout(vdl)
	);

	// r.v products
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				rv_s5[i] <= $signed(u_r[i]) * $signed(vdl[i]);
			end
		end
	end

	// specular cosine
	assign drv = rv_s5[0] + rv_s5[1] + rv_s5[2];

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s6 <= (drv > 0) ? drv[29:14] : '0;
		end
	end

	pfs_power u_power (.clk(clk), .en(adv), .cos_in(s_s6), .shin(shin_q), .pow(pow));

	pfs_delay #(.W(D_W), .DEPTH(D_DLY)) u_dly_d (
		.clk(clk), .en(adv), .din(d_s4), .dout(d_dl)
	);

	pfs_delay #(.W(27), .DEPTH(B_DLY)) u_dly_base (
		.clk(clk), .en(adv), .din(base_in), .dout(base_dl)
	);

	pfs_delay #(.W(20), .DEPTH(TOTAL)) u_dly_pix (
		.clk(clk), .en(adv), .din(pix_in), .dout(pix_dl)
	);

	pfs_light u_light (
		.clk   (clk),
		.en    (adv),
		.base  (base_dl),
		.amb   (amb_q),
		.lrgb  (lrgb_q),
		.gain  (gain_q),
		.diff  (d_dl),
		.spec  (pow),
		.color (color)
	);

	// output packing
	assign m_tdata = {4'd0, color, pix_dl};

endmodule

FILE: src/pfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_checker: port-level checks of the fragment shader
// Output holding under stall, pipeline flow control and reset behavior.
// ----------------------------------------------------------------------------
module pfs_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [47:0]  m_tdata
);
	// a stalled pixel stays and holds its data
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output pixel changed");

	// input ready is high exactly when the output side is free
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	// a held output blocks new fragments on the next cycle too, unless m_tready is then high
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> !s_tready || m_tready)
		else $error("fragment taken while output stalled");

	// nothing comes out right after reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_tvalid)
		else $error("output valid right after reset");

endmodule

bind phong_fragment_shader_core pfs_checker u_pfs_checker (.*);
